// ===== src/sensor_field_crc8_assembler_unit_assert.svh =====
// Assertion macros for the sensor field assembler.
// Depends on nothing; included by sfca_field_core, the one module that carries assertions.
`ifndef SENSOR_FIELD_CRC8_ASSEMBLER_UNIT_ASSERT_SVH
`define SENSOR_FIELD_CRC8_ASSEMBLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SFCA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfca assertion failed");
`define SFCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfca assertion failed");
`else
`define SFCA_ASSERT(lbl, clk, rst, prop)
`define SFCA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/sfca_pkg.sv =====
// Package for the sensor field assembler: configuration types, register map and CRC step.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sfca_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_FIELD_BYTES = 3'd0;
  localparam logic [2:0] REG_MSB_FIRST   = 3'd1;
  localparam logic [2:0] REG_CRC_ENABLE  = 3'd2;
  localparam logic [2:0] REG_CRC_TAPS    = 3'd3;
  localparam logic [2:0] REG_CRC_START   = 3'd4;

  localparam logic [2:0] RST_FIELD_BYTES = 3'd2;
  localparam logic       RST_MSB_FIRST   = 1'b1;
  localparam logic       RST_CRC_ENABLE  = 1'b0;
  localparam logic [7:0] RST_CRC_TAPS    = 8'h31;
  localparam logic [7:0] RST_CRC_START   = 8'hFF;

  typedef struct packed {
    logic [2:0] field_bytes;
    logic       msb_first;
    logic       crc_enable;
    logic [7:0] crc_taps;
    logic [7:0] crc_start;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_field;
  } item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/sfca_byte_if.sv =====
// Channel interfaces: received bytes in, assembled field results out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sfca_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_field;

  modport source (output valid, output data_byte, output start_of_field, input ready);
  modport sink (input valid, input data_byte, input start_of_field, output ready);
endinterface

interface sfca_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_value;
  logic        check_passed;

  modport source (output valid, output field_value, output check_passed, input ready);
  modport sink (input valid, input field_value, input check_passed, output ready);
endinterface

`default_nettype wire

// ===== src/sensor_field_crc8_assembler_unit.sv =====
// Top level of the sensor field assembler with CRC-8 check.
// Depends on sfca_pkg, the channel interfaces, sfca_cfg_regs, sfca_in_stage and sfca_field_core.
//
// Accepts one received byte per clock cycle and emits one result per completed field: the
// assembled value (1 to MAX_BYTES data bytes, big- or little-endian) and a pass flag from an
// optional trailing CRC-8 byte. A byte passes through an input register and the field logic
// (one unrolled eight-step CRC update and the byte merge) into the result register; the byte that
// ends the field is registered in the input register and its result then in the result register.
// While each result is read as it appears, the sustained rate is one byte per cycle. A result
// that waits in the result register holds the next byte in the input register, and with it the
// input, until the result is read; the register frees in the cycle it is read. Configuration is
// written through the APB-style port at byte addresses 0 to 16.
`timescale 1ns / 1ps
`default_nettype none

module sensor_field_crc8_assembler_unit #(
  parameter int MAX_BYTES = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sfca_byte_if.sink                         byte_in,
  sfca_result_if.source                     result_out,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfca_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sfca_pkg::DATA_W-1:0]  pwdata,
  output logic      [sfca_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  sfca_pkg::cfg_t  cfg;
  sfca_pkg::item_t item;
  logic            item_valid;
  logic            take;

  sfca_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfca_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sfca_field_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ===== src/sfca_cfg_regs.sv =====
// APB-style configuration registers of the sensor field assembler.
// Depends on sfca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfca_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfca_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sfca_pkg::DATA_W-1:0]  pwdata,
  output logic      [sfca_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output sfca_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_bytes <= sfca_pkg::RST_FIELD_BYTES;
      cfg.msb_first   <= sfca_pkg::RST_MSB_FIRST;
      cfg.crc_enable  <= sfca_pkg::RST_CRC_ENABLE;
      cfg.crc_taps    <= sfca_pkg::RST_CRC_TAPS;
      cfg.crc_start   <= sfca_pkg::RST_CRC_START;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfca_pkg::REG_FIELD_BYTES: cfg.field_bytes <= pwdata[2:0];
        sfca_pkg::REG_MSB_FIRST:   cfg.msb_first   <= pwdata[0];
        sfca_pkg::REG_CRC_ENABLE:  cfg.crc_enable  <= pwdata[0];
        sfca_pkg::REG_CRC_TAPS:    cfg.crc_taps    <= pwdata[7:0];
        sfca_pkg::REG_CRC_START:   cfg.crc_start   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfca_pkg::REG_FIELD_BYTES: prdata = {29'd0, cfg.field_bytes};
      sfca_pkg::REG_MSB_FIRST:   prdata = {31'd0, cfg.msb_first};
      sfca_pkg::REG_CRC_ENABLE:  prdata = {31'd0, cfg.crc_enable};
      sfca_pkg::REG_CRC_TAPS:    prdata = {24'd0, cfg.crc_taps};
      sfca_pkg::REG_CRC_START:   prdata = {24'd0, cfg.crc_start};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sfca_in_stage.sv =====
// Input register of the sensor field assembler: holds one received byte until the core takes it.
// Depends on sfca_pkg and sfca_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module sfca_in_stage (
  input  wire logic      clk,
  input  wire logic      rst,
  sfca_byte_if.sink      byte_in,
  input  wire logic      take,
  output logic           item_valid,
  output sfca_pkg::item_t item
);

  assign byte_in.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_in.ready) begin
      item_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      item.data_byte      <= byte_in.data_byte;
      item.start_of_field <= byte_in.start_of_field;
    end
  end

endmodule

`default_nettype wire

// ===== src/sfca_field_core.sv =====
// Field state, CRC-8 update, value assembly and result register of the sensor field assembler.
// Depends on sfca_pkg, sfca_result_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_field_crc8_assembler_unit_assert.svh"

module sfca_field_core #(
  parameter int MAX_BYTES = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sfca_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire sfca_pkg::item_t item,
  output logic                 take,
  sfca_result_if.source        result_out
);

  localparam int POS_W = $clog2(MAX_BYTES + 1);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_crc, running_crc_next;
  logic [31:0]      value_accumulator, value_accumulator_next;

  logic             o_valid;
  logic [31:0]      o_value;
  logic             o_passed;

  logic [POS_W-1:0] len;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       crc_base;
  logic [31:0]      acc_base;
  logic [31:0]      acc_new;
  logic             emit;
  logic [31:0]      emit_value;
  logic             emit_passed;
  logic [7:0]       b;

  assign take = item_valid && (!o_valid || result_out.ready);
  assign b    = item.data_byte;

  always_comb begin
    if (cfg.field_bytes == 3'd0) begin
      len = POS_W'(1);
    end else if (int'(cfg.field_bytes) > MAX_BYTES) begin
      len = POS_W'(MAX_BYTES);
    end else begin
      len = POS_W'(cfg.field_bytes);
    end
  end

  always_comb begin
    byte_position_next     = byte_position;
    running_crc_next       = running_crc;
    value_accumulator_next = value_accumulator;
    emit                   = 1'b0;
    emit_value             = value_accumulator;
    emit_passed            = 1'b1;
    pos                    = item.start_of_field ? '0 : byte_position;
    crc_base               = running_crc;
    acc_base               = value_accumulator;
    acc_new                = value_accumulator;
    pos_inc                = '0;

    if (pos >= len && cfg.crc_enable) begin
      emit                = 1'b1;
      emit_value          = value_accumulator;
      emit_passed         = (running_crc == b);
      byte_position_next  = '0;
    end else begin
      if (pos >= len) begin
        pos = '0;
      end
      if (pos == '0) begin
        crc_base = cfg.crc_start;
        acc_base = '0;
      end
      running_crc_next = sfca_pkg::crc8_step(crc_base, b, cfg.crc_taps);
      if (cfg.msb_first) begin
        acc_new = {acc_base[23:0], b};
      end else if (int'(pos) < 4) begin
        acc_new = acc_base | (32'(b) << {pos, 3'b000});
      end else begin
        acc_new = acc_base;
      end
      value_accumulator_next = acc_new;
      pos_inc = pos + POS_W'(1);
      if (pos_inc >= len && !cfg.crc_enable) begin
        emit               = 1'b1;
        emit_value         = acc_new;
        emit_passed        = 1'b1;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      running_crc       <= '0;
      value_accumulator <= '0;
    end else if (take) begin
      byte_position     <= byte_position_next;
      running_crc       <= running_crc_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (take) begin
      o_valid <= emit;
    end else if (result_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      o_value  <= emit_value;
      o_passed <= emit_passed;
    end
  end

  assign result_out.valid        = o_valid;
  assign result_out.field_value  = o_value;
  assign result_out.check_passed = o_passed;

  `SFCA_ASSERT(a_pos_in_range, clk, rst, int'(byte_position) <= MAX_BYTES)
  `SFCA_ASSERT(a_result_from_item, clk, rst, $rose(o_valid) |-> $past(take))
  `SFCA_ASSERT(a_fail_needs_crc, clk, rst, (o_valid && !o_passed) |-> cfg.crc_enable)
  `SFCA_ASSERT_NEXT(a_stall_holds_state, clk, rst, !take, $stable(byte_position))

endmodule

`default_nettype wire
